### hdl/awde_pkg.sv
`default_nettype none

package awde_pkg;

    // sample and width sizes
    localparam int SAMPLE_W = 16;
    localparam int WIDTH_W  = 5;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [WIDTH_W-1:0]  width_t;

    // token control codes
    typedef enum logic [1:0] {
        CODE_SAME  = 2'd0,
        CODE_INC   = 2'd1,
        CODE_DEC   = 2'd2,
        CODE_RESET = 2'd3
    } ctrl_code_t;

    // width adaptation constants
    localparam width_t RAW_WIDTH       = width_t'(SAMPLE_W);
    localparam width_t MAX_WIDTH       = width_t'(SAMPLE_W);
    localparam width_t MIN_WIDTH       = width_t'(2);
    localparam width_t FIRST_INC_WIDTH = width_t'(4);
    localparam width_t INC_STEP        = width_t'(2);
    localparam width_t INC_LIMIT       = width_t'(2);
    localparam width_t DEC_LIMIT       = width_t'(4);

    // minimal signed width of a difference: 0 for zero, else 2..16
    function automatic width_t needed_width(input sample_t d);
        sample_t y;
        width_t  len;
        y   = d[SAMPLE_W-1] ? ~d : d;
        len = '0;
        for (int i = 0; i < SAMPLE_W; i++)
        begin
            if (y[i])
            begin
                len = width_t'(i + 1);
            end
        end
        if (d == '0)
        begin
            return '0;
        end
        else if (len == '0)
        begin
            return MIN_WIDTH;
        end
        else
        begin
            return len + width_t'(1);
        end
    endfunction

    // mask with the low w bits set
    function automatic sample_t low_mask(input width_t w);
        sample_t m;
        for (int i = 0; i < SAMPLE_W; i++)
        begin
            m[i] = (width_t'(i) < w);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

### hdl/adaptive_width_delta_encoder_core.sv
`default_nettype none

// channel  | valid         | stall         | payload
// ---------+---------------+---------------+----------------------------------------------
// input    | sample_valid  | sample_stall  | sample, start_block
// output   | token_valid   | token_stall   | is_raw, ctrl_code, reset_width,
//          |               |               | payload_width, payload
//
// one sample per cycle sustained while the token is not stalled; a token is built from its
// sample via the input register, then the delta/width logic feeding the token register
// rst_n clears the valid flags, the previous sample and the running width
// a stalled token holds; the input register keeps taking samples while it drains,
// and sample_stall rises only when both registers are full and the token is stalled

module adaptive_width_delta_encoder_core (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   sample_valid,
    output logic                        sample_stall,
    input  wire logic [awde_pkg::SAMPLE_W-1:0] sample,
    input  wire logic                   start_block,
    output logic                        token_valid,
    input  wire logic                   token_stall,
    output logic                        is_raw,
    output logic [1:0]                  ctrl_code,
    output logic [awde_pkg::WIDTH_W-1:0] reset_width,
    output logic [awde_pkg::WIDTH_W-1:0] payload_width,
    output logic [awde_pkg::SAMPLE_W-1:0] payload
);

    import awde_pkg::*;

    logic       in_valid_reg;
    logic       in_valid_next;
    sample_t    in_sample_reg;
    logic       in_start_reg;

    sample_t    prev_sample_reg;
    sample_t    prev_sample_next;
    width_t     cur_width_reg;
    width_t     cur_width_next;

    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_raw_reg;
    logic       out_raw_next;
    ctrl_code_t out_code_reg;
    ctrl_code_t out_code_next;
    width_t     out_rw_reg;
    width_t     out_rw_next;
    width_t     out_pw_reg;
    width_t     out_pw_next;
    sample_t    out_payload_reg;
    sample_t    out_payload_next;

    logic       out_free;
    logic       advance;
    logic       in_load;

    sample_t    diff;
    width_t     need;
    width_t     adapt_width;
    ctrl_code_t adapt_code;
    width_t     inc_width;

    // handshake between the two registers
    assign out_free     = !out_valid_reg || !token_stall;
    assign advance      = in_valid_reg && out_free;
    assign sample_stall = in_valid_reg && !out_free;
    assign in_load      = sample_valid && !sample_stall;

    assign in_valid_next  = in_load || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && token_stall);

    // delta and needed width
    assign diff = prev_sample_reg - in_sample_reg;
    assign need = needed_width(diff);

    // running width adaptation
    always_comb
    begin
        inc_width   = cur_width_reg + INC_STEP;
        adapt_width = need;
        adapt_code  = CODE_SAME;
        if (need == cur_width_reg)
        begin
            adapt_code = CODE_SAME;
        end
        else if (need > cur_width_reg)
        begin
            if ((need - cur_width_reg) > INC_LIMIT)
            begin
                adapt_code = CODE_RESET;
            end
            else
            begin
                adapt_code = CODE_INC;
                if (cur_width_reg == '0)
                begin
                    adapt_width = FIRST_INC_WIDTH;
                end
                else if (inc_width > MAX_WIDTH)
                begin
                    adapt_width = MAX_WIDTH;
                end
                else
                begin
                    adapt_width = inc_width;
                end
            end
        end
        else
        begin
            if ((cur_width_reg - need) >= DEC_LIMIT)
            begin
                adapt_code = CODE_RESET;
            end
            else
            begin
                adapt_code  = CODE_DEC;
                adapt_width = (cur_width_reg == MIN_WIDTH) ? '0
                                                           : cur_width_reg - width_t'(1);
            end
        end
    end

    // token fields and state update
    always_comb
    begin
        out_raw_next     = out_raw_reg;
        out_code_next    = out_code_reg;
        out_rw_next      = out_rw_reg;
        out_pw_next      = out_pw_reg;
        out_payload_next = out_payload_reg;
        prev_sample_next = prev_sample_reg;
        cur_width_next   = cur_width_reg;
        if (advance)
        begin
            prev_sample_next = in_sample_reg;
            if (in_start_reg)
            begin
                out_raw_next     = 1'b1;
                out_code_next    = CODE_SAME;
                out_rw_next      = '0;
                out_pw_next      = RAW_WIDTH;
                out_payload_next = in_sample_reg;
                cur_width_next   = '0;
            end
            else
            begin
                out_raw_next     = 1'b0;
                out_code_next    = adapt_code;
                out_rw_next      = (adapt_code == CODE_RESET) ? adapt_width : '0;
                out_pw_next      = adapt_width;
                out_payload_next = diff & low_mask(adapt_width);
                cur_width_next   = adapt_width;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            prev_sample_reg <= '0;
            cur_width_reg   <= '0;
        end
        else
        begin
            in_valid_reg    <= in_valid_next;
            out_valid_reg   <= out_valid_next;
            prev_sample_reg <= prev_sample_next;
            cur_width_reg   <= cur_width_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_sample_reg <= sample;
            in_start_reg  <= start_block;
        end
        out_raw_reg     <= out_raw_next;
        out_code_reg    <= out_code_next;
        out_rw_reg      <= out_rw_next;
        out_pw_reg      <= out_pw_next;
        out_payload_reg <= out_payload_next;
    end

    assign token_valid   = out_valid_reg;
    assign is_raw        = out_raw_reg;
    assign ctrl_code     = 2'(out_code_reg);
    assign reset_width   = out_rw_reg;
    assign payload_width = out_pw_reg;
    assign payload       = out_payload_reg;

endmodule

`default_nettype wire

### hdl/awde_checker.sv
`default_nettype none

module awde_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            sample_valid,
    input wire logic                            sample_stall,
    input wire logic [awde_pkg::SAMPLE_W-1:0]   sample,
    input wire logic                            start_block,
    input wire logic                            token_valid,
    input wire logic                            token_stall,
    input wire logic                            is_raw,
    input wire logic [1:0]                      ctrl_code,
    input wire logic [awde_pkg::WIDTH_W-1:0]    reset_width,
    input wire logic [awde_pkg::WIDTH_W-1:0]    payload_width,
    input wire logic [awde_pkg::SAMPLE_W-1:0]   payload
);

    import awde_pkg::*;

    // a stalled token keeps its fields
    assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_stall |=>
            token_valid && $stable(payload) && $stable(payload_width)
            && $stable(ctrl_code) && $stable(is_raw))
    else $error("stalled token changed");

    // raw tokens carry the full sample with a neutral code
    assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && is_raw |->
            payload_width == RAW_WIDTH && ctrl_code == 2'(CODE_SAME) && reset_width == '0)
    else $error("raw token fields wrong");

    // explicit width only with the reset code, and then it is the payload width
    assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && !is_raw |->
            (ctrl_code == 2'(CODE_RESET) && reset_width == payload_width)
            || (ctrl_code != 2'(CODE_RESET) && reset_width == '0))
    else $error("reset width inconsistent with code");

    // payload fits its width; width is 0 or 2..16
    assert property (@(posedge clk) disable iff (!rst_n)
        token_valid |->
            ((payload & ~low_mask(payload_width)) == '0)
            && payload_width != width_t'(1) && payload_width <= MAX_WIDTH)
    else $error("payload outside its width");

endmodule

bind adaptive_width_delta_encoder_core awde_checker u_awde_checker (.*);

`default_nettype wire

### dv/adaptive_width_delta_encoder_core_test.sv
`timescale 1ns / 100ps

module adaptive_width_delta_encoder_core_test;

    import awde_pkg::*;

    localparam int RANDOM_SAMPLES   = 1030;
    localparam int LONG_HOLD_AT     = 400;
    localparam int LONG_HOLD_CYCLES = 64;

    // one pending sample with the idle cycles before it
    typedef struct {
        sample_t value;
        logic    start;
        int      gap;
        bit      drain;
    } sample_item_t;

    // one encoded token
    typedef struct packed {
        logic       is_raw;
        ctrl_code_t code;
        width_t     reset_w;
        width_t     payload_w;
        sample_t    payload;
    } token_t;

    logic    clk;
    logic    rst_n = 1'b0;
    logic    sample_valid = 1'b0;
    logic    sample_stall;
    sample_t sample = '0;
    logic    start_block = 1'b0;
    logic    token_valid;
    logic    token_stall = 1'b0;
    logic    is_raw;
    logic [1:0] ctrl_code;
    width_t  reset_width;
    width_t  payload_width;
    sample_t payload;

    sample_item_t sample_q[$];
    token_t       expected_tokens[$];
    sample_item_t head_item;
    token_t       want;

    // encoder state as seen by the predictor
    sample_t prev_sample = '0;
    width_t  run_width = '0;

    int gap_count = 0;
    int hold_left = 0;
    int n_sent = 0;
    int n_tokens = 0;
    int n_errors = 0;
    int n_raw = 0;
    int code_seen[4] = '{0, 0, 0, 0};

    adaptive_width_delta_encoder_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_valid  (sample_valid),
        .sample_stall  (sample_stall),
        .sample        (sample),
        .start_block   (start_block),
        .token_valid   (token_valid),
        .token_stall   (token_stall),
        .is_raw        (is_raw),
        .ctrl_code     (ctrl_code),
        .reset_width   (reset_width),
        .payload_width (payload_width),
        .payload       (payload)
    );

    // smallest two's-complement width that holds a difference
    function automatic int signed_width(input sample_t diff);
        sample_t mag;
        int      bits;
        mag  = diff[SAMPLE_W-1] ? ~diff : diff;
        bits = 0;
        while (mag != '0)
        begin
            bits++;
            mag = mag >> 1;
        end
        if (diff == '0)
        begin
            return 0;
        end
        return (bits + 1 < MIN_WIDTH) ? int'(MIN_WIDTH) : bits + 1;
    endfunction

    // token for one sample, advancing the predictor state
    function automatic token_t encode_sample(input sample_t value, input logic start);
        token_t  tok;
        sample_t diff;
        int      need;
        int      cur;
        int      nxt;
        if (start)
        begin
            tok.is_raw    = 1'b1;
            tok.code      = CODE_SAME;
            tok.reset_w   = '0;
            tok.payload_w = RAW_WIDTH;
            tok.payload   = value;
            prev_sample   = value;
            run_width     = '0;
            return tok;
        end
        diff = prev_sample - value;
        need = signed_width(diff);
        cur  = run_width;
        nxt  = need;
        // width adaptation
        if (need == cur)
        begin
            tok.code = CODE_SAME;
        end
        else if (need > cur)
        begin
            if (need - cur > INC_LIMIT)
            begin
                tok.code = CODE_RESET;
            end
            else
            begin
                tok.code = CODE_INC;
                if (cur == 0)
                    nxt = FIRST_INC_WIDTH;
                else
                    nxt = (cur + INC_STEP > MAX_WIDTH) ? int'(MAX_WIDTH) : cur + INC_STEP;
            end
        end
        else
        begin
            if (cur - need >= DEC_LIMIT)
            begin
                tok.code = CODE_RESET;
            end
            else
            begin
                tok.code = CODE_DEC;
                nxt = (cur == MIN_WIDTH) ? 0 : cur - 1;
            end
        end
        tok.is_raw    = 1'b0;
        tok.reset_w   = (tok.code == CODE_RESET) ? width_t'(nxt) : '0;
        tok.payload_w = width_t'(nxt);
        tok.payload   = (nxt == 0) ? '0 : sample_t'(32'(diff) & ((32'd1 << nxt) - 1));
        prev_sample   = value;
        run_width     = width_t'(nxt);
        return tok;
    endfunction

    // queue a sample; gaps vanish in every third stretch of 64
    task automatic push_sample(input sample_t value, input logic start, input bit drain);
        sample_item_t item;
        item.value = value;
        item.start = start;
        item.drain = drain;
        item.gap   = ((sample_q.size() / 64) % 3 == 0) ? 0 : $urandom_range(0, 5);
        sample_q.push_back(item);
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // sample driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            sample       <= '0;
            start_block  <= 1'b0;
            gap_count = 0;
        end
        else
        begin
            // predict the token of an accepted transfer
            if (sample_valid && !sample_stall)
            begin
                expected_tokens.push_back(encode_sample(sample, start_block));
                n_sent++;
            end
            // offer the next sample once the current one is gone
            if (!sample_valid || !sample_stall)
            begin
                if (sample_q.size() == 0)
                begin
                    sample_valid <= 1'b0;
                end
                else if (gap_count < sample_q[0].gap)
                begin
                    gap_count++;
                    sample_valid <= 1'b0;
                end
                else if (sample_q[0].drain && expected_tokens.size() != 0)
                begin
                    sample_valid <= 1'b0;
                end
                else
                begin
                    head_item = sample_q.pop_front();
                    sample_valid <= 1'b1;
                    sample       <= head_item.value;
                    start_block  <= head_item.start;
                    gap_count = 0;
                end
            end
        end
    end

    // token monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_stall <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (token_valid && !token_stall)
            begin
                if (expected_tokens.size() == 0)
                begin
                    $error("token transfer with no token expected");
                    n_errors++;
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (is_raw !== want.is_raw)
                    begin
                        $error("is_raw: expected %0d, actual %0d", want.is_raw, is_raw);
                        n_errors++;
                    end
                    if (ctrl_code !== want.code)
                    begin
                        $error("ctrl_code: expected %0d, actual %0d", want.code, ctrl_code);
                        n_errors++;
                    end
                    if (reset_width !== want.reset_w)
                    begin
                        $error("reset_width: expected %0d, actual %0d", want.reset_w,
                               reset_width);
                        n_errors++;
                    end
                    if (payload_width !== want.payload_w)
                    begin
                        $error("payload_width: expected %0d, actual %0d", want.payload_w,
                               payload_width);
                        n_errors++;
                    end
                    if (payload !== want.payload)
                    begin
                        $error("payload: expected 0x%04h, actual 0x%04h", want.payload, payload);
                        n_errors++;
                    end
                    if (want.is_raw)
                        n_raw++;
                    else
                        code_seen[want.code]++;
                end
                n_tokens++;
                // one long hold-off, calm stretches, otherwise short random stalls
                if (n_tokens == LONG_HOLD_AT)
                    hold_left = LONG_HOLD_CYCLES;
                else if ((n_tokens / 80) % 3 == 1)
                    hold_left = 0;
                else
                    hold_left = $urandom_range(0, 5);
            end
            else if (hold_left > 0)
            begin
                hold_left--;
            end
            token_stall <= (hold_left != 0);
        end
    end

    // timeout
    initial
    begin
        #1000000;
        $display("Test completed with failures");
        $finish;
    end

    // stimulus and end of run
    initial
    begin
        sample_t walk;
        sample_t step;
        int      run_left;
        int      span;
        bit      drain;

        // delta with no block started, raw extremes
        push_sample(16'h0005, 1'b0, 1'b0);
        push_sample(16'h8000, 1'b1, 1'b0);
        push_sample(16'h7FFF, 1'b1, 1'b0);
        // walk through same, increase, decrease and reset width
        push_sample(16'h0000, 1'b1, 1'b0);
        push_sample(16'h0000, 1'b0, 1'b0);
        push_sample(16'hFFFF, 1'b0, 1'b0);
        push_sample(16'hFFFF, 1'b0, 1'b0);
        push_sample(16'h0001, 1'b0, 1'b0);
        push_sample(16'h0003, 1'b0, 1'b0);
        push_sample(16'h0006, 1'b0, 1'b0);
        push_sample(16'h0008, 1'b0, 1'b0);
        push_sample(16'h0008, 1'b0, 1'b0);
        // wide deltas, increase capped at full width, extreme differences
        push_sample(16'hE000, 1'b0, 1'b0);
        push_sample(16'h6008, 1'b0, 1'b0);
        push_sample(16'hE009, 1'b0, 1'b0);
        push_sample(16'h6009, 1'b0, 1'b0);
        push_sample(16'h6009, 1'b0, 1'b0);
        push_sample(16'h7FFF, 1'b0, 1'b0);
        push_sample(16'h8000, 1'b0, 1'b0);
        push_sample(16'h8000, 1'b0, 1'b0);

        // random blocks of walks with deltas of random size, plus noise
        walk     = '0;
        run_left = 0;
        for (int i = 0; i < RANDOM_SAMPLES; i++)
        begin
            drain = (i % 200 == 0);
            if ($urandom_range(0, 9) == 0)
            begin
                push_sample(sample_t'($urandom), 1'($urandom_range(0, 1)), drain);
            end
            else if (run_left == 0)
            begin
                run_left = $urandom_range(1, 40);
                walk     = sample_t'($urandom);
                push_sample(walk, 1'b1, drain);
            end
            else
            begin
                span = $urandom_range(0, 16);
                step = sample_t'($urandom) & sample_t'((32'd1 << span) - 1);
                if ($urandom_range(0, 1) == 1)
                    step = -step;
                walk = walk - step;
                push_sample(walk, 1'b0, drain);
                run_left--;
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // wait for every transfer, then every token, then the pipeline latency
        while (sample_q.size() != 0 || sample_valid)
            @(posedge clk);
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("encoded %0d samples into %0d tokens (%0d raw)", n_sent, n_tokens, n_raw);
        $display("width codes: same %0d, increase %0d, decrease %0d, reset %0d",
                 code_seen[CODE_SAME], code_seen[CODE_INC], code_seen[CODE_DEC],
                 code_seen[CODE_RESET]);
        if (n_errors == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### sim.f
hdl/awde_pkg.sv
hdl/adaptive_width_delta_encoder_core.sv
hdl/awde_checker.sv
dv/adaptive_width_delta_encoder_core_test.sv
